### design/mma_pkg.sv
package mma_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_WINDOW_DEF   = 256;

	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 3;
	localparam int NCH_W    = 4;
	localparam int WIN_W    = 9;
	localparam int CFG_W    = 9;

	localparam logic REG_NUM_CHANNELS = 1'b0;
	localparam logic REG_WINDOW_LEN   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

endpackage

### design/multichannel_moving_average.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  tdata: sample; tuser: restart
// m_        out        m_tvalid/m_tready  tdata: average; tuser: channel
// cfg_      in         cfg_we only        cfg_index selects, cfg_data value
//
// Each item passes through these steps in order: the trailing sample is read
// from the history RAM, the channel sum is updated, the shared restoring
// divider divides the sum by the window (one quotient bit per cycle), the
// result is handed to the output register, and the block returns to idle.
// Reset clears the sums and all counters at once; the history RAM is not
// cleared. A stalled output register holds its item while the next one is
// accepted and processed; only its final hand-off waits for the register.
module multichannel_moving_average #(
	parameter int MAX_CHANNELS = mma_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW   = mma_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mma_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                          s_tuser,   // [0] restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mma_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] average
	output logic [mma_pkg::CHAN_W-1:0]    m_tuser,   // [2:0] channel
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mma_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SW     = mma_pkg::SAMPLE_W;
	localparam int WW     = mma_pkg::WIN_W;
	localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int DEPTH  = MAX_CHANNELS * MAX_WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W  = SW + $clog2(MAX_WINDOW) + 1;
	localparam int CNT_W  = $clog2(SUM_W);

	mma_pkg::state_t state_q;

	logic [mma_pkg::NCH_W-1:0] num_channels_q;
	logic [WW-1:0]             window_len_q;

	logic signed [SUM_W-1:0] sums_q [MAX_CHANNELS];
	logic [POS_W-1:0]        pos_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [WW-1:0]           frames_q;

	logic [SW-1:0]    sample_q;
	logic [POS_W-1:0] ch_q;

	logic [SUM_W-1:0] dvd_q;
	logic [WW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	logic [4:0]              nc_eff;
	logic [WW-1:0]           w_eff;
	logic [ADDR_W-1:0]       addr;
	logic [SW-1:0]           hist;
	logic signed [SUM_W-1:0] old_sub;
	logic signed [SUM_W-1:0] new_sum;
	logic [WW:0]             trial;
	logic                    q_bit;
	logic [SW-1:0]           quot;
	logic                    out_free;
	logic                    clear_run;

	always_comb begin
		if (num_channels_q == '0) begin
			nc_eff = 5'd1;
		end else if (int'(num_channels_q) > MAX_CHANNELS) begin
			nc_eff = 5'(MAX_CHANNELS);
		end else begin
			nc_eff = {1'b0, num_channels_q};
		end
		if (window_len_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(window_len_q) > MAX_WINDOW) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = window_len_q;
		end
	end

	assign addr = ADDR_W'(slot_q) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(pos_q);

	mma_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (state_q == mma_pkg::ST_UPDATE),
		.waddr(addr),
		.wdata(sample_q),
		.raddr(addr),
		.rdata(hist)
	);

	// The trailing sample drops out only once a full window has been seen.
	assign old_sub = (frames_q >= w_eff) ? {{(SUM_W-SW){hist[SW-1]}}, hist} : '0;
	assign new_sum = sums_q[pos_q] - old_sub + {{(SUM_W-SW){sample_q[SW-1]}}, sample_q};

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit = (trial >= {1'b0, w_eff});
	assign quot  = neg_q ? SW'(-dvd_q) : dvd_q[SW-1:0];

	assign s_tready = (state_q == mma_pkg::ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	// A register write or a restart item clears the run state.
	assign clear_run = cfg_we || (state_q == mma_pkg::ST_IDLE && s_tvalid && s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mma_pkg::ST_IDLE;
			num_channels_q <= mma_pkg::NCH_W'(1);
			window_len_q   <= WW'(1);
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
			pos_q    <= '0;
			slot_q   <= '0;
			frames_q <= '0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == mma_pkg::ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					mma_pkg::REG_NUM_CHANNELS: num_channels_q <= cfg_data[mma_pkg::NCH_W-1:0];
					mma_pkg::REG_WINDOW_LEN:   window_len_q   <= cfg_data[WW-1:0];
					default: ;
				endcase
			end

			if (clear_run) begin
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					sums_q[i] <= '0;
				end
				pos_q    <= '0;
				slot_q   <= '0;
				frames_q <= '0;
			end else if (state_q == mma_pkg::ST_UPDATE) begin
				sums_q[pos_q] <= new_sum;
				if (5'(pos_q) + 5'd1 >= nc_eff) begin
					pos_q <= '0;
					if (int'(slot_q) + 1 >= int'(w_eff)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					if (frames_q < w_eff) begin
						frames_q <= frames_q + WW'(1);
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end

			unique case (state_q)
				mma_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= mma_pkg::ST_READ;
					end
				end
				mma_pkg::ST_READ: begin
					state_q <= mma_pkg::ST_UPDATE;
				end
				mma_pkg::ST_UPDATE: begin
					cnt_q   <= '0;
					state_q <= mma_pkg::ST_DIVIDE;
				end
				mma_pkg::ST_DIVIDE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= mma_pkg::ST_DONE;
					end
				end
				mma_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mma_pkg::ST_IDLE;
					end
				end
				default: state_q <= mma_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mma_pkg::ST_IDLE && s_tvalid) begin
			sample_q <= s_tdata;
		end
		if (state_q == mma_pkg::ST_READ) begin
			ch_q <= pos_q;
		end
		if (state_q == mma_pkg::ST_UPDATE) begin
			// The divider works on the magnitude; the sign is applied at the end.
			neg_q <= new_sum[SUM_W-1];
			dvd_q <= new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
			rem_q <= '0;
		end
		if (state_q == mma_pkg::ST_DIVIDE) begin
			rem_q <= q_bit ? WW'(trial - {1'b0, w_eff}) : trial[WW-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
		end
		if (state_q == mma_pkg::ST_DONE && out_free) begin
			m_tdata <= quot;
			m_tuser <= mma_pkg::CHAN_W'(ch_q);
		end
	end

endmodule

### design/mma_ram.sv
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [mma_pkg::SAMPLE_W-1:0] average;
		logic [mma_pkg::CHAN_W-1:0]   channel;
	} avg_result_t;

	typedef enum int {
		SMP_RANDOM,
		SMP_SMALL,
		SMP_EXTREME,
		SMP_FIXED
	} sample_style_t;

	localparam int SETTLE_CYCLES = 40;
	localparam int ITEM_TARGET   = 1900;

	// Running-sum boxcar predictor: per-channel sums, sample history and the
	// frame counters, plus the queue of averages still owed by the block.
	class boxcar_predictor_t;
		logic [mma_pkg::NCH_W-1:0] chan_reg = 4'd1;
		logic [mma_pkg::WIN_W-1:0] win_reg  = 9'd1;
		int                sums[mma_pkg::MAX_CHANNELS_DEF];
		logic signed [15:0] history[mma_pkg::MAX_CHANNELS_DEF * mma_pkg::MAX_WINDOW_DEF];
		int                pos;
		int                slot;
		int                frames;
		avg_result_t       pending[$];
		int                mismatches;

		function void clear_run();
			foreach (sums[i]) sums[i] = 0;
			pos = 0;
			slot = 0;
			frames = 0;
		endfunction

		function void set_register(logic idx, logic [mma_pkg::CFG_W-1:0] value);
			if (idx == mma_pkg::REG_NUM_CHANNELS)
				chan_reg = value[mma_pkg::NCH_W-1:0];
			else
				win_reg = value[mma_pkg::WIN_W-1:0];
			clear_run();
		endfunction

		function void take_sample(logic [mma_pkg::SAMPLE_W-1:0] raw, logic restart);
			int s;
			int nc;
			int w;
			int ch;
			int idx;
			avg_result_t r;
			s = $signed(raw);
			nc = (chan_reg == 0) ? 1
				: (chan_reg > mma_pkg::MAX_CHANNELS_DEF) ? mma_pkg::MAX_CHANNELS_DEF
				: int'(chan_reg);
			w = (win_reg == 0) ? 1
				: (win_reg > mma_pkg::MAX_WINDOW_DEF) ? mma_pkg::MAX_WINDOW_DEF
				: int'(win_reg);
			if (restart)
				clear_run();
			if (pos >= nc) pos = 0;
			if (slot >= w) slot = 0;
			if (frames > w) frames = w;
			ch = pos;
			idx = slot * mma_pkg::MAX_CHANNELS_DEF + ch;
			// Once the window has filled, the oldest sample of this channel drops out.
			if (frames >= w)
				sums[ch] -= int'(history[idx]);
			sums[ch] += s;
			history[idx] = raw;
			r.average = 16'(sums[ch] / w);
			r.channel = 3'(ch);
			pending.push_back(r);
			pos = ch + 1;
			if (pos >= nc) begin
				pos = 0;
				slot = (slot + 1 >= w) ? 0 : slot + 1;
				if (frames < w)
					frames++;
			end
		endfunction

		function void check_average(logic [mma_pkg::SAMPLE_W-1:0] avg,
				logic [mma_pkg::CHAN_W-1:0] ch);
			avg_result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected average %0d on channel %0d",
						$realtime, $signed(avg), ch);
				return;
			end
			exp_r = pending.pop_front();
			if (avg !== exp_r.average || ch !== exp_r.channel) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: average mismatch: expected %0d ch %0d, got %0d ch %0d",
						$realtime, $signed(exp_r.average), exp_r.channel,
						$signed(avg), ch);
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [mma_pkg::SAMPLE_W-1:0] s_tdata = '0;   // [15:0] sample
	logic                         s_tuser = 1'b0; // [0] restart
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [mma_pkg::SAMPLE_W-1:0] m_tdata;        // [15:0] average
	logic [mma_pkg::CHAN_W-1:0]   m_tuser;        // [2:0] channel
	logic                         cfg_we = 1'b0;
	logic                         cfg_index = 1'b0;
	logic [mma_pkg::CFG_W-1:0]    cfg_data = '0;

	boxcar_predictor_t pred;
	int              burst_left = 0;
	int              items_sent = 0;
	int unsigned     stall_tick = 0;
	int              stall_mode = 0;
	int              hold_left = 0;
	logic            hold_level = 1'b0;

	multichannel_moving_average DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			pred.check_average(m_tdata, m_tuser);
		if (arst_n && s_tvalid && s_tready)
			pred.take_sample(s_tdata, s_tuser);
	end

	// Receiver: switches at random between always ready, coin flips, a sparse
	// fixed pattern and long held levels.
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 700 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (stall_tick % 5) == 0;
			default: begin
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 45);
					hold_level = ~hold_level;
				end
				hold_left--;
				m_tready <= hold_level;
			end
		endcase
	end

	task automatic push_item(logic [mma_pkg::SAMPLE_W-1:0] smp, logic restart);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, $urandom_range(1, 40));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stop sending and wait until every owed average has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pred.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [mma_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		pred.set_register(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [mma_pkg::SAMPLE_W-1:0] pick_sample(sample_style_t style,
			logic [mma_pkg::SAMPLE_W-1:0] fixed);
		case (style)
			SMP_SMALL:   return 16'($signed($urandom_range(0, 16)) - 8);
			SMP_EXTREME: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			SMP_FIXED:   return fixed;
			default:     return 16'($urandom);
		endcase
	endfunction

	initial begin
		int nc_val;
		int win_val;
		int nc_eff;
		int win_eff;
		int n_items;
		int cut;
		bit with_restart;
		sample_style_t style;
		logic [mma_pkg::SAMPLE_W-1:0] fixed;

		pred = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: one channel, window of one.
		push_item(16'h7FFF, 1'b0);
		push_item(16'h8000, 1'b0);
		push_item(16'h0000, 1'b0);
		push_item(16'hFFFF, 1'b0);
		push_item(16'h0001, 1'b1);
		push_item(16'hAAAA, 1'b0);
		drain();

		// Zero channel count and zero window both act as one.
		write_reg(mma_pkg::REG_NUM_CHANNELS, 9'd0);
		write_reg(mma_pkg::REG_WINDOW_LEN, 9'd0);
		push_item(16'h8000, 1'b0);
		push_item(16'h5555, 1'b0);
		drain();

		// Oversized values saturate to eight channels and a 256-sample window.
		write_reg(mma_pkg::REG_NUM_CHANNELS, 9'h1FF);
		write_reg(mma_pkg::REG_WINDOW_LEN, 9'h1FF);
		for (int i = 0; i < 8; i++)
			push_item(i[0] ? 16'h8000 : 16'h7FFF, 1'b0);
		drain();

		// Negative partial sums truncate toward zero; restart lands on a frame boundary.
		write_reg(mma_pkg::REG_NUM_CHANNELS, 9'd3);
		write_reg(mma_pkg::REG_WINDOW_LEN, 9'd2);
		push_item(16'hFFFD, 1'b0);
		push_item(16'hFFFF, 1'b0);
		push_item(16'h0005, 1'b0);
		push_item(16'h0007, 1'b0);
		push_item(16'hFFF9, 1'b0);
		push_item(16'h0003, 1'b0);
		push_item(16'hFFFB, 1'b1);
		push_item(16'h0001, 1'b0);
		drain();

		// Full 256 window on one channel driven to both sum extremes.
		write_reg(mma_pkg::REG_NUM_CHANNELS, 9'd1);
		write_reg(mma_pkg::REG_WINDOW_LEN, 9'd256);
		for (int i = 0; i < 300; i++)
			push_item(16'h7FFF, 1'b0);
		for (int i = 0; i < 300; i++)
			push_item(16'h8000, 1'b0);
		drain();

		while (items_sent < ITEM_TARGET) begin
			nc_val = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 511);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: win_val = $urandom_range(1, 8);
				6, 7, 8:          win_val = $urandom_range(9, 32);
				default:          win_val = $urandom_range(0, 511);
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(mma_pkg::REG_NUM_CHANNELS, 9'(nc_val));
				write_reg(mma_pkg::REG_WINDOW_LEN, 9'(win_val));
			end else begin
				write_reg(mma_pkg::REG_WINDOW_LEN, 9'(win_val));
				write_reg(mma_pkg::REG_NUM_CHANNELS, 9'(nc_val));
			end
			nc_eff = nc_val % 16;
			nc_eff = (nc_eff == 0) ? 1 : (nc_eff > 8) ? 8 : nc_eff;
			win_eff = (win_val == 0) ? 1 : (win_val > 256) ? 256 : win_val;
			n_items = $urandom_range(10, 60) + 2 * nc_eff * win_eff;
			if (n_items > 400)
				n_items = 400;
			cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_items - 1) : -1;
			with_restart = $urandom_range(0, 2) == 0;
			case ($urandom_range(0, 5))
				0, 1, 2: style = SMP_RANDOM;
				3:       style = SMP_SMALL;
				4:       style = SMP_EXTREME;
				default: style = SMP_FIXED;
			endcase
			fixed = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			for (int i = 0; i < n_items; i++) begin
				if (i == cut)
					drain();
				push_item(pick_sample(style, fixed),
					with_restart && ($urandom_range(0, 63) == 0));
			end
			drain();
		end

		if (pred.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
